// ----- sv/markov_substitution_jump_sampler_core_macros.svh -----
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef MARKOV_SUBSTITUTION_JUMP_SAMPLER_CORE_MACROS_SVH
`define MARKOV_SUBSTITUTION_JUMP_SAMPLER_CORE_MACROS_SVH

// same-cycle implication
`define MSJS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msjs: same-cycle check failed");

// next-cycle implication
`define MSJS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msjs: next-cycle check failed");

`endif

// ----- sv/msjs_pkg.sv -----
package msjs_pkg;

  localparam int TIME_W      = 24;
  localparam int BASE_W      = 2;
  localparam int FRAC_W      = 16;
  localparam int MEAN_W      = 16;
  localparam int ROW_W       = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int PROD_W      = MEAN_W + FRAC_W;
  localparam int STEP_SHIFT  = 12;
  localparam int STEP_W      = PROD_W - STEP_SHIFT;

  localparam logic [TIME_W-1:0] TIME_MAX            = '1;
  localparam logic [TIME_W-1:0] COURSE_LENGTH_RESET = 24'd655360;
  localparam logic [BASE_W-1:0] START_BASE_RESET    = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_BASE    = 3'd0,
    CFG_COURSE_LENGTH = 3'd1,
    CFG_ROW_A         = 3'd2,
    CFG_ROW_C         = 3'd3,
    CFG_ROW_G         = 3'd4,
    CFG_ROW_T         = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [FRAC_W-1:0] u_time;
    logic [FRAC_W-1:0] u_choice;
  } item_t;

  typedef struct packed {
    logic [BASE_W-1:0] new_base;
    logic [TIME_W-1:0] position;
    logic              site_done;
  } result_t;

  // ln(1 + idx / 2^bits) in Q0.16, rounded to nearest
  function automatic logic [FRAC_W-1:0] log_entry(int bits, int idx);
    real x;
    x = $ln(1.0 + real'(idx) * (2.0 ** (-bits)));
    return FRAC_W'($rtoi(x * 65536.0 + 0.5));
  endfunction

endpackage

// ----- sv/msjs_stream_if.sv -----
interface msjs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/markov_substitution_jump_sampler_core.sv -----
// An input transaction is registered in stage one, and its result is loaded into the result
// register when that register is free; a stall on results holds stage one.
// Throughput: one transaction per cycle unless results stalls; stage one reads the log ROM,
// stage two does the multiply, saturating add, course compare and base/time state update.
// Reset (rst, synchronous): start base 2, course length 10.0, rows zero, site at the
// start base with time zero, both stages empty.
`include "markov_substitution_jump_sampler_core_macros.svh"

module markov_substitution_jump_sampler_core #(
  parameter int LOG_TABLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [msjs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [msjs_pkg::ROW_W-1:0]        cfg_data,
  msjs_stream_if.sink                       items,
  msjs_stream_if.source                     results
);
  import msjs_pkg::*;

  localparam int LOG_DEPTH = 1 << LOG_TABLE_BITS;

  typedef logic [FRAC_W-1:0] rom_t [LOG_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      r[i] = log_entry(LOG_TABLE_BITS, i);
    end
    return r;
  endfunction

  localparam rom_t LOG_ROM = build_rom();

  // configuration
  logic [BASE_W-1:0] start_base;
  logic [TIME_W-1:0] course_length;
  logic [ROW_W-1:0]  row [4];

  // site state
  logic [BASE_W-1:0] current_base;
  logic [TIME_W-1:0] elapsed_time;

  // stage one
  logic              a_valid;
  logic [FRAC_W-1:0] a_choice;
  logic [FRAC_W-1:0] rom_q;

  // output register
  logic              res_valid;
  result_t           res_q;

  logic              out_free;
  logic              advance;
  logic              accept;

  logic [ROW_W-1:0]  row_sel;
  logic [FRAC_W-1:0] thr1;
  logic [FRAC_W-1:0] thr2;
  logic [MEAN_W-1:0] mean;
  logic [PROD_W-1:0] product;
  logic [STEP_W-1:0] step;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] t_sat;
  logic [1:0]        slot;
  logic [BASE_W-1:0] nb;
  logic              done;

  assign out_free    = !res_valid || results.ready;
  assign advance     = a_valid && out_free;
  assign items.ready = !a_valid || out_free;
  assign accept      = items.valid && items.ready;

  assign results.valid   = res_valid;
  assign results.payload = res_q;

  always_comb begin
    row_sel = row[current_base];
    thr1    = row_sel[47:32];
    thr2    = row_sel[31:16];
    mean    = row_sel[15:0];
    product = mean * rom_q;
    step    = product[PROD_W-1:STEP_SHIFT];
    sum     = {1'b0, elapsed_time} + {{(TIME_W + 1 - STEP_W){1'b0}}, step};
    t_sat   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    if (a_choice < thr1) begin
      slot = 2'd0;
    end else if (a_choice < thr2) begin
      slot = 2'd1;
    end else begin
      slot = 2'd2;
    end
    nb   = (slot < current_base) ? slot : slot + 2'd1;
    done = (t_sat >= course_length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_base    <= START_BASE_RESET;
      course_length <= COURSE_LENGTH_RESET;
      for (int i = 0; i < 4; i++) begin
        row[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BASE:    start_base    <= cfg_data[BASE_W-1:0];
        CFG_COURSE_LENGTH: course_length <= cfg_data[TIME_W-1:0];
        CFG_ROW_A:         row[0]        <= cfg_data;
        CFG_ROW_C:         row[1]        <= cfg_data;
        CFG_ROW_G:         row[2]        <= cfg_data;
        CFG_ROW_T:         row[3]        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_choice <= items.payload.u_choice;
      rom_q    <= LOG_ROM[items.payload.u_time[FRAC_W-1 -: LOG_TABLE_BITS]];
    end
    if (advance) begin
      res_q.new_base  <= nb;
      res_q.position  <= t_sat;
      res_q.site_done <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      res_valid    <= 1'b0;
      current_base <= START_BASE_RESET;
      elapsed_time <= '0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      if (advance) begin
        if (done) begin
          current_base <= start_base;
          elapsed_time <= '0;
        end else begin
          current_base <= nb;
          elapsed_time <= t_sat;
        end
      end
    end
  end

  `MSJS_ASSERT_NOW(a_jump_changes_base, advance, nb != current_base)
  `MSJS_ASSERT_NOW(a_time_monotonic, advance, t_sat >= elapsed_time)
  `MSJS_ASSERT_NEXT(a_restart_clears_time, advance && done, elapsed_time == '0)
  `MSJS_ASSERT_NOW(a_empty_stage_ready, !a_valid, items.ready)

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import msjs_pkg::*;

  localparam int LN_BITS = 10;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;

  msjs_stream_if #(.payload_t(item_t)) items_if ();
  msjs_stream_if #(.payload_t(result_t)) results_if ();

  markov_substitution_jump_sampler_core #(.LOG_TABLE_BITS(LN_BITS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .items    (items_if),
    .results  (results_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies and site state of the predictor
  logic [BASE_W-1:0] home_base = START_BASE_RESET;
  logic [TIME_W-1:0] course_len = COURSE_LENGTH_RESET;
  logic [ROW_W-1:0] base_rows [4] = '{default: '0};
  logic [BASE_W-1:0] site_base = START_BASE_RESET;
  logic [TIME_W-1:0] site_time = '0;
  logic [FRAC_W-1:0] ln_q16_table [1 << LN_BITS];

  item_t pending_items[$];
  result_t expected_jumps[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 1;
  bit quiet = 1'b1;
  logic [15:0] ready_mask = '1;
  logic [3:0] stall_step = '0;

  // ln(1 + i/2^LN_BITS) in Q0.16 via 2*atanh(i/(2n+i)), Q60 intermediates
  function automatic logic [FRAC_W-1:0] ln_q16(int unsigned i);
    logic [127:0] z, z2, term;
    logic [63:0] sum, d;
    int k;
    d = 64'(2 * (1 << LN_BITS) + i);
    z = (128'(i) << 60) / d;
    z2 = (z * z) >> 60;
    term = z;
    sum = '0;
    for (k = 0; k < 48 && term != 0; k++) begin
      sum += 64'(term / (2 * k + 1));
      term = (term * z2) >> 60;
    end
    sum = sum * 2;
    return FRAC_W'((sum + (64'd1 << 43)) >> 44);
  endfunction

  task automatic predict_jump(item_t it);
    logic [ROW_W-1:0] row;
    logic [FRAC_W-1:0] lnv;
    logic [PROD_W-1:0] prod;
    logic [TIME_W:0] sum;
    logic [1:0] slot;
    result_t r;
    row = base_rows[site_base];
    lnv = ln_q16_table[it.u_time >> (FRAC_W - LN_BITS)];
    prod = PROD_W'(row[15:0]) * PROD_W'(lnv);
    sum = {1'b0, site_time} + (TIME_W + 1)'(prod >> STEP_SHIFT);
    r.position = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
    if (it.u_choice < row[47:32])
      slot = 2'd0;
    else if (it.u_choice < row[31:16])
      slot = 2'd1;
    else
      slot = 2'd2;
    r.new_base = (slot < site_base) ? slot : slot + 2'd1;
    r.site_done = (r.position >= course_len);
    expected_jumps.push_back(r);
    if (r.site_done) begin
      site_base = home_base;
      site_time = '0;
    end else begin
      site_base = r.new_base;
      site_time = r.position;
    end
  endtask

  task automatic report_mismatch(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // sender: bursts of random length, random gaps between them (no gaps while quiet)
  always @(posedge clk) begin : sender
    logic held;
    if (rst) begin
      items_if.valid <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      if (items_if.valid && items_if.ready)
        predict_jump(items_if.payload);
      held = items_if.valid && !items_if.ready;
      if (!held) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0)
            gap_left--;
          items_if.valid <= 1'b0;
        end else begin
          items_if.payload <= pending_items.pop_front();
          items_if.valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = quiet ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: stalls on a rotating mask (never stalls while quiet)
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      stall_step <= '0;
    end else begin
      results_if.ready <= quiet || ready_mask[stall_step];
      stall_step <= stall_step + 4'd1;
    end
  end

  always @(posedge clk) begin : monitor
    result_t got, want;
    if (!rst && results_if.valid && results_if.ready) begin
      got = results_if.payload;
      if (expected_jumps.size() == 0) begin
        report_mismatch("unexpected transaction, position", got.position, '0);
      end else begin
        want = expected_jumps.pop_front();
        if (got.new_base !== want.new_base)
          report_mismatch("new_base", TIME_W'(got.new_base), TIME_W'(want.new_base));
        if (got.position !== want.position)
          report_mismatch("position", got.position, want.position);
        if (got.site_done !== want.site_done)
          report_mismatch("site_done", TIME_W'(got.site_done), TIME_W'(want.site_done));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (items_if.valid && items_if.ready)
        || (results_if.valid && results_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ROW_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_BASE: home_base = val[BASE_W-1:0];
      CFG_COURSE_LENGTH: course_len = val[TIME_W-1:0];
      CFG_ROW_A, CFG_ROW_C, CFG_ROW_G, CFG_ROW_T: base_rows[2'(idx - CFG_ROW_A)] = val;
      default: ;
    endcase
  endtask

  task automatic queue_item(logic [FRAC_W-1:0] ut, logic [FRAC_W-1:0] uc);
    item_t it;
    it.u_time = ut;
    it.u_choice = uc;
    pending_items.push_back(it);
  endtask

  // checked between edges so that the sender's updates have settled
  task automatic drain();
    while (pending_items.size() != 0 || items_if.valid || expected_jumps.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [FRAC_W-1:0] random_frac();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] random_row(bit long_holds);
    logic [FRAC_W-1:0] t1, t2, t3, m;
    t1 = random_frac();
    t2 = random_frac();
    if ($urandom_range(0, 4) != 0 && t1 > t2) begin
      t3 = t1;
      t1 = t2;
      t2 = t3;
    end
    case ($urandom_range(0, 7))
      0: m = '0;
      1: m = '1;
      default: m = long_holds ? FRAC_W'($urandom_range(16'h8000, 16'hFFFF)) : FRAC_W'($urandom);
    endcase
    return {t1, t2, m};
  endfunction

  initial begin : stimulus
    logic [TIME_W-1:0] course;
    int p, n, b;
    items_if.valid = 1'b0;
    items_if.payload = '0;
    results_if.ready = 1'b0;
    for (n = 0; n < (1 << LN_BITS); n++)
      ln_q16_table[n] = ln_q16(n);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: all rows zero, so time stands still and the last other base is taken
    queue_item(16'h0000, 16'h0000);
    queue_item(16'hFFFF, 16'hFFFF);
    queue_item(16'h8000, 16'h1234);
    drain();

    write_reg(CFG_START_BASE, 48'h0);
    write_reg(CFG_COURSE_LENGTH, 48'h0C0000);
    write_reg(CFG_ROW_A, 48'h4000_C000_1000);
    write_reg(CFG_ROW_C, 48'h1000_2000_FFFF);
    write_reg(CFG_ROW_G, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_ROW_T, 48'h8000_4000_0800);
    write_reg(CFG_SPARE_LO, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_SPARE_HI, 48'hFFFF_FFFF_FFFF);
    quiet = 1'b0;
    ready_mask = 16'hB6D9;
    queue_item(16'h0000, 16'h0000);
    queue_item(16'hFFFF, 16'h3FFF);
    queue_item(16'h0040, 16'h4000);
    queue_item(16'hFFC0, 16'hBFFF);
    queue_item(16'h7FFF, 16'hC000);
    queue_item(16'hFFFF, 16'hFFFF);
    queue_item(16'h003F, 16'h7FFF);
    queue_item(16'hA5A5, 16'h5A5A);
    drain();

    // zero course length: every jump closes the site
    write_reg(CFG_START_BASE, 48'h3);
    write_reg(CFG_COURSE_LENGTH, 48'h0);
    queue_item(16'h1234, 16'hFFFF);
    queue_item(16'h0000, 16'h0000);
    queue_item(16'hFFFF, 16'h8000);
    drain();

    write_reg(CFG_START_BASE, 48'h5555_5555_5555);
    write_reg(CFG_COURSE_LENGTH, 48'hABCD_EFFF_FFFF);
    for (b = 0; b < 4; b++)
      write_reg(CFG_INDEX_W'(CFG_ROW_A + b), '1);
    queue_item(16'hFFFF, 16'hFFFE);
    queue_item(16'hFFFF, 16'h0001);
    queue_item(16'hFFFF, 16'hFFFF);
    queue_item(16'hFFFF, 16'h0000);
    drain();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(CFG_START_BASE, {ROW_W'($urandom) << BASE_W} | ROW_W'($urandom_range(0, 3)));
      case (p)
        2: course = '0;
        5: course = TIME_MAX;
        6: course = TIME_W'($urandom);
        default: course = TIME_W'($urandom_range(1, 24'h300000));
      endcase
      write_reg(CFG_COURSE_LENGTH, {24'($urandom), course});
      for (b = 0; b < 4; b++)
        write_reg(CFG_INDEX_W'(CFG_ROW_A + b), random_row(p == 5));
      quiet = (p == 0 || p == 4);
      ready_mask = 16'($urandom) | 16'h0001;
      for (n = 0; n < ITEMS_PER_PHASE; n++)
        pending_items.push_back({random_frac(), random_frac()});
      drain();
    end

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
